[sv/rau_pkg.sv]
// Package for the rational arithmetic unit: widths, operation codes,
// state encoding and request/result beat types. No dependencies.
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int NUM_W         = OPERAND_WIDTH;
    localparam int DEN_W         = OPERAND_WIDTH - 1;
    localparam int RES_NUM_W     = 32;
    localparam int RES_DEN_W     = 31;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_MUL_C,
        S_MUL_D,
        S_MAG,
        S_GCD,
        S_GMOD,
        S_QNUM,
        S_QDEN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op                     req_type;
        logic signed [NUM_W-1:0] a_num;
        logic [DEN_W-1:0]        a_den;
        logic signed [NUM_W-1:0] b_num;
        logic [DEN_W-1:0]        b_den;
    } t_req;

    typedef struct packed {
        logic signed [RES_NUM_W-1:0] res_num;
        logic [RES_DEN_W-1:0]        res_den;
        logic                        div_zero;
    } t_res;

endpackage

[sv/rational_arith_unit.sv]
// Rational arithmetic unit: cross products on a shared multiplier, then
// Euclid GCD and reduction on one shared restoring divider. Uses rau_pkg.
// Sequence: cross products on the multiplier, then per Euclid step a setup state and a
// divider run, then two divider runs to reduce and a register for the result; the Euclid
// steps are skipped when a part is zero. One item in flight; the next request is taken
// the cycle after the result is registered. Reset (synchronous, active low) drops any beat.
module rational_arith_unit
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_res o_out
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W + 1;
    localparam int MW = 2 * W;
    localparam int CW = $clog2(MW);
    localparam int EW = (MW > 33) ? MW : 33;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_res   r_out, n_out;
    t_req   r_req, n_req;

    logic signed [MW-1:0] r_prod, n_prod;
    logic signed [PW-1:0] r_num, n_num;
    logic signed [PW-1:0] r_den, n_den;
    logic                 r_sn, n_sn;
    logic                 r_sd, n_sd;
    logic [MW-1:0]        r_an, n_an;
    logic [MW-1:0]        r_ad, n_ad;
    logic [MW-1:0]        r_x, n_x;
    logic [MW-1:0]        r_y, n_y;
    logic [MW-1:0]        r_g, n_g;
    logic [MW-1:0]        r_qn, n_qn;
    logic [MW-1:0]        r_dvd, n_dvd;
    logic [MW-1:0]        r_dvs, n_dvs;
    logic [MW-1:0]        r_rem, n_rem;
    logic [CW-1:0]        r_cnt, n_cnt;

    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [MW-1:0] mul_p;
    logic [MW:0]          div_t, div_r;
    logic                 div_ge, div_last;
    logic [MW-1:0]        div_q, div_rem;
    logic [PW-1:0]        num_abs, den_abs;
    logic [EW-1:0]        qn_ext, qd_ext;
    logic                 neg;
    t_res                 res;

    assign mul_p = mul_a * mul_b;

    assign div_t    = {r_rem, r_dvd[MW-1]};
    assign div_ge   = div_t >= {1'b0, r_dvs};
    assign div_r    = div_ge ? (div_t - {1'b0, r_dvs}) : div_t;
    assign div_rem  = div_r[MW-1:0];
    assign div_q    = {r_dvd[MW-2:0], div_ge};
    assign div_last = (r_cnt == CW'(MW - 1));

    assign num_abs = r_num[PW-1] ? (-r_num) : r_num;
    assign den_abs = r_den[PW-1] ? (-r_den) : r_den;

    always_comb begin
        qn_ext = EW'(r_qn);
        qd_ext = EW'(div_q);
        neg    = r_sn ^ r_sd;
        res    = '0;
        if (r_an == '0) begin
            res.res_num = '0;
            res.res_den = RES_DEN_W'(1);
        end else begin
            if (neg) begin
                if (qn_ext > EW'(64'h8000_0000)) begin
                    res.res_num = 32'sh8000_0000;
                end else begin
                    res.res_num = -qn_ext[RES_NUM_W-1:0];
                end
            end else begin
                if (qn_ext > EW'(64'h7FFF_FFFF)) begin
                    res.res_num = 32'sh7FFF_FFFF;
                end else begin
                    res.res_num = qn_ext[RES_NUM_W-1:0];
                end
            end
            if (qd_ext > EW'(64'h7FFF_FFFF)) begin
                res.res_den = 31'h7FFF_FFFF;
            end else begin
                res.res_den = qd_ext[RES_DEN_W-1:0];
            end
            res.div_zero = (r_ad == '0);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_req       = r_req;
        n_prod      = r_prod;
        n_num       = r_num;
        n_den       = r_den;
        n_sn        = r_sn;
        n_sd        = r_sd;
        n_an        = r_an;
        n_ad        = r_ad;
        n_x         = r_x;
        n_y         = r_y;
        n_g         = r_g;
        n_qn        = r_qn;
        n_dvd       = div_q;
        n_dvs       = r_dvs;
        n_rem       = div_rem;
        n_cnt       = r_cnt + CW'(1);
        mul_a       = r_req.a_num;
        mul_b       = signed'({1'b0, r_req.b_den});
        o_in_ready  = (r_state == S_IDLE);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in;
                    n_state = S_MUL_A;
                end
            end
            S_MUL_A: begin
                mul_a = r_req.a_num;
                mul_b = (r_req.req_type == OP_MUL) ? r_req.b_num
                                                   : signed'({1'b0, r_req.b_den});
                n_prod  = mul_p;
                n_state = S_MUL_B;
            end
            S_MUL_B: begin
                mul_a   = signed'({1'b0, r_req.a_den});
                mul_b   = r_req.b_num;
                n_num   = {r_prod[MW-1], r_prod};
                n_prod  = mul_p;
                n_state = S_MUL_C;
            end
            S_MUL_C: begin
                mul_a = signed'({1'b0, r_req.a_den});
                mul_b = signed'({1'b0, r_req.b_den});
                case (r_req.req_type)
                    OP_ADD:  n_num = r_num + {r_prod[MW-1], r_prod};
                    OP_SUB:  n_num = r_num - {r_prod[MW-1], r_prod};
                    OP_DIV:  n_den = {r_prod[MW-1], r_prod};
                    default: n_num = r_num;
                endcase
                n_prod  = mul_p;
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                if (r_req.req_type != OP_DIV) begin
                    n_den = {r_prod[MW-1], r_prod};
                end
                n_state = S_MAG;
            end
            S_MAG: begin
                n_sn = r_num[PW-1];
                n_sd = r_den[PW-1];
                n_an = num_abs[MW-1:0];
                n_ad = den_abs[MW-1:0];
                n_x  = num_abs[MW-1:0];
                n_y  = den_abs[MW-1:0];
                if (num_abs == '0 || den_abs == '0) begin
                    n_g     = MW'(1);
                    n_dvd   = num_abs[MW-1:0];
                    n_dvs   = MW'(1);
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_QNUM;
                end else begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                n_rem = '0;
                n_cnt = '0;
                if (r_y == '0) begin
                    n_g     = r_x;
                    n_dvd   = r_an;
                    n_dvs   = r_x;
                    n_state = S_QNUM;
                end else begin
                    n_dvd   = r_x;
                    n_dvs   = r_y;
                    n_state = S_GMOD;
                end
            end
            S_GMOD: begin
                if (div_last) begin
                    n_x     = r_y;
                    n_y     = div_rem;
                    n_state = S_GCD;
                end
            end
            S_QNUM: begin
                if (div_last) begin
                    n_qn    = div_q;
                    n_dvd   = r_ad;
                    n_dvs   = r_g;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_QDEN;
                end
            end
            S_QDEN: begin
                if (div_last) begin
                    n_state = S_DONE;
                    n_rem   = r_rem;
                    n_dvd   = r_dvd;
                    n_cnt   = r_cnt;
                end
            end
            S_DONE: begin
                n_dvd = r_dvd;
                n_rem = r_rem;
                n_cnt = r_cnt;
                if (!r_out_valid || i_out_ready) begin
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The divider registers hold their last-step values in S_DONE, so div_q still gives the final quotient.

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_req  <= n_req;
        r_prod <= n_prod;
        r_num  <= n_num;
        r_den  <= n_den;
        r_sn   <= n_sn;
        r_sd   <= n_sd;
        r_an   <= n_an;
        r_ad   <= n_ad;
        r_x    <= n_x;
        r_y    <= n_y;
        r_g    <= n_g;
        r_qn   <= n_qn;
        r_dvd  <= n_dvd;
        r_dvs  <= n_dvs;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
